>>> sv/lpwg_pkg.sv
// Shared types, operation codes, register indexes and constants for the
// transmit pulse generator. No dependencies.
package lpwg_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_SHAPE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAUSS_RATE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LENGTH = 3'd4;

	localparam logic        RST_PULSE_SHAPE   = 1'b0;
	localparam logic [15:0] RST_AMPLITUDE     = 16'd65535;
	localparam logic [31:0] RST_GAUSS_RATE    = 32'd1073741824;
	localparam logic [15:0] RST_PULSE_WIDTH   = 16'd16;
	localparam logic [15:0] RST_RECORD_LENGTH = 16'd1024;

	localparam logic SHAPE_GAUSS = 1'b0;
	localparam logic SHAPE_RECT  = 1'b1;

	// exp(-u) series: terms 1..TAYLOR_TERMS, then SQUARINGS squarings
	localparam int TAYLOR_TERMS = 13;
	localparam int SQUARINGS    = 4;
	localparam logic [31:0] Q31_ONE = 32'h8000_0000;
	localparam logic [63:0] Q31_HALF = 64'h0000_0000_4000_0000;

	typedef logic [3:0] op_t;
	typedef logic [3:0] term_k_t;

	localparam op_t OP_NONE  = 4'd0;
	localparam op_t OP_LOAD  = 4'd1;  // take tick, fix index and last flag
	localparam op_t OP_SQ    = 4'd2;  // t*t
	localparam op_t OP_XLO   = 4'd3;  // low word of t*t times rate
	localparam op_t OP_XHI   = 4'd4;  // high bits of t*t times rate, range check
	localparam op_t OP_TMUL  = 4'd5;  // term times u
	localparam op_t OP_TDIV  = 4'd6;  // times reciprocal of k
	localparam op_t OP_TFIX  = 4'd7;  // quotient correction, accumulate
	localparam op_t OP_SQR   = 4'd8;  // e = e*e rounded
	localparam op_t OP_AMP   = 4'd9;  // scale by amplitude
	localparam op_t OP_ZERO  = 4'd10;
	localparam op_t OP_RECT  = 4'd11;
	localparam op_t OP_EMIT  = 4'd12;

	typedef struct packed {
		op_t     op;
		term_k_t k;
	} cmd_t;

	typedef struct packed {
		logic shape;
		logic zero;
	} stat_t;

	typedef struct packed {
		logic restart;
	} in_item_t;

	typedef struct packed {
		logic [15:0] sample;
		logic [15:0] sample_index;
		logic        last;
	} out_item_t;

	// floor(2^31 / k) for the series divisors
	function automatic logic [31:0] recip_q31(input term_k_t k);
		logic [31:0] r;
		unique case (k)
			4'd1:    r = 32'd2147483648;
			4'd2:    r = 32'd1073741824;
			4'd3:    r = 32'd715827882;
			4'd4:    r = 32'd536870912;
			4'd5:    r = 32'd429496729;
			4'd6:    r = 32'd357913941;
			4'd7:    r = 32'd306783378;
			4'd8:    r = 32'd268435456;
			4'd9:    r = 32'd238609294;
			4'd10:   r = 32'd214748364;
			4'd11:   r = 32'd195225786;
			4'd12:   r = 32'd178956970;
			4'd13:   r = 32'd165191049;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

>>> sv/lpwg_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Payload types come from lpwg_pkg at the point of instantiation.
interface lpwg_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/lidar_pulse_waveform_generator.sv
// Transmit pulse record generator. Every transfer on tick yields one transfer
// on result: a sample of the pulse record at a running index, its index, and
// a last flag on the final sample, after which the index wraps to 0; restart
// forces index 0 first. Gaussian mode gives round(amplitude*exp(-t*t*rate))
// with record_length+1 samples; rectangular mode gives amplitude while the
// index is below pulse_width, over record_length samples. One tick is worked
// at a time. A Gaussian sample runs the exp series of 13 terms and 4
// squarings, each term taking a multiply and a divide on the one shared
// 32x32 multiplier and a quotient correction; an argument of 16 or more skips
// the series and gives 0. A finished result sits in the output register, so
// the next tick is taken while it waits. Write registers only while idle.
module lidar_pulse_waveform_generator #(
	parameter int SAMPLE_BITS = 16,
	parameter int INDEX_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lpwg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lpwg_pkg::CFG_DATA_W-1:0] cfg_wdata,
	lpwg_stream_if.sink                     tick,
	lpwg_stream_if.source                   result
);

	lpwg_pkg::cmd_t      cmd;
	lpwg_pkg::stat_t     stat;
	lpwg_pkg::out_item_t out_item;
	logic                in_ready;
	logic                out_valid;

	lpwg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tick.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lpwg_dp #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.INDEX_BITS  (INDEX_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.restart   (tick.data.restart),
		.cmd       (cmd),
		.stat      (stat),
		.out_item  (out_item)
	);

	assign tick.ready   = in_ready;
	assign result.valid = out_valid;
	assign result.data  = out_item;

	// a finished sample never overwrites one that is still pending
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == lpwg_pkg::OP_EMIT |-> (!result.valid || result.ready))
		else $error("result overwritten while pending");

	// one tick in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		tick.valid && tick.ready |=> !tick.ready)
		else $error("second tick taken while busy");

	// series divisor stays inside the reciprocal table
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == lpwg_pkg::OP_TDIV || cmd.op == lpwg_pkg::OP_TFIX)
		|-> (cmd.k >= 4'd1 && cmd.k <= 4'd13))
		else $error("series divisor out of range");

endmodule

>>> sv/lpwg_ctrl.sv
// Sequencer for the pulse generator: walks the datapath through one sample
// and owns the input and output handshakes. Uses lpwg_pkg.
module lpwg_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  lpwg_pkg::stat_t stat,
	output lpwg_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RECT = 4'd1;
	localparam logic [3:0] S_SQ   = 4'd2;
	localparam logic [3:0] S_XLO  = 4'd3;
	localparam logic [3:0] S_XHI  = 4'd4;
	localparam logic [3:0] S_CHK  = 4'd5;
	localparam logic [3:0] S_TMUL = 4'd6;
	localparam logic [3:0] S_TDIV = 4'd7;
	localparam logic [3:0] S_TFIX = 4'd8;
	localparam logic [3:0] S_SQR  = 4'd9;
	localparam logic [3:0] S_AMP  = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;

	localparam lpwg_pkg::term_k_t K_LAST = lpwg_pkg::term_k_t'(lpwg_pkg::TAYLOR_TERMS);
	localparam logic [1:0] SQ_LAST = 2'(lpwg_pkg::SQUARINGS - 1);

	logic [3:0]          state_q, state_d;
	lpwg_pkg::term_k_t   k_q, k_d;
	logic [1:0]          sqr_q, sqr_d;
	logic                out_valid_q;
	logic                emit;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign emit      = (cmd.op == lpwg_pkg::OP_EMIT);

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		sqr_d   = sqr_q;
		cmd.op  = lpwg_pkg::OP_NONE;
		cmd.k   = k_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = lpwg_pkg::OP_LOAD;
					state_d = (stat.shape == lpwg_pkg::SHAPE_RECT) ? S_RECT : S_SQ;
				end
			end
			S_RECT: begin
				cmd.op  = lpwg_pkg::OP_RECT;
				state_d = S_DONE;
			end
			S_SQ: begin
				cmd.op  = lpwg_pkg::OP_SQ;
				state_d = S_XLO;
			end
			S_XLO: begin
				cmd.op  = lpwg_pkg::OP_XLO;
				state_d = S_XHI;
			end
			S_XHI: begin
				cmd.op  = lpwg_pkg::OP_XHI;
				state_d = S_CHK;
			end
			S_CHK: begin
				k_d = 4'd1;
				if (stat.zero) begin
					cmd.op  = lpwg_pkg::OP_ZERO;
					state_d = S_DONE;
				end else begin
					state_d = S_TMUL;
				end
			end
			S_TMUL: begin
				cmd.op  = lpwg_pkg::OP_TMUL;
				state_d = S_TDIV;
			end
			S_TDIV: begin
				cmd.op  = lpwg_pkg::OP_TDIV;
				state_d = S_TFIX;
			end
			S_TFIX: begin
				cmd.op = lpwg_pkg::OP_TFIX;
				if (k_q == K_LAST) begin
					sqr_d   = 2'd0;
					state_d = S_SQR;
				end else begin
					k_d     = k_q + 4'd1;
					state_d = S_TMUL;
				end
			end
			S_SQR: begin
				cmd.op = lpwg_pkg::OP_SQR;
				sqr_d  = sqr_q + 2'd1;
				if (sqr_q == SQ_LAST)
					state_d = S_AMP;
			end
			S_AMP: begin
				cmd.op  = lpwg_pkg::OP_AMP;
				state_d = S_DONE;
			end
			S_DONE: begin
				// hold until the output register is free or draining
				if (!out_valid_q || out_ready) begin
					cmd.op  = lpwg_pkg::OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= 4'd1;
			sqr_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			sqr_q   <= sqr_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> sv/lpwg_dp.sv
// Datapath of the pulse generator: configuration registers, index counter,
// one shared 32x32 multiplier and the output register. Uses lpwg_pkg.
module lpwg_dp #(
	parameter int SAMPLE_BITS = 16,
	parameter int INDEX_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lpwg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lpwg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              restart,
	input  lpwg_pkg::cmd_t                    cmd,
	output lpwg_pkg::stat_t                   stat,
	output lpwg_pkg::out_item_t               out_item
);

	localparam int CMP_W = (INDEX_BITS > 16) ? INDEX_BITS : 16;
	localparam int SQ_W  = 2 * INDEX_BITS;
	localparam logic [15:0] SAMPLE_MASK =
		(SAMPLE_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << SAMPLE_BITS) - 64'd1);

	// configuration
	logic        shape_q;
	logic [15:0] amp_q;
	logic [31:0] rate_q;
	logic [15:0] width_q;
	logic [15:0] reclen_q;

	// per-sample state
	logic [INDEX_BITS-1:0] idx_q;
	logic [INDEX_BITS-1:0] t_q;
	logic                  last_q;
	logic [SQ_W-1:0]       sq_q;
	logic [63:0]           p_q;
	logic                  zero_q;
	logic [30:0]           u_q;
	logic [31:0]           term_q;
	logic [31:0]           sum_q;
	logic [30:0]           p31_q;
	logic [30:0]           qe_q;
	logic [15:0]           res_q;
	lpwg_pkg::out_item_t   out_q;

	logic [31:0]           mul_a, mul_b;
	logic [63:0]           prod;
	logic [63:0]           prod_rnd;
	logic [63:0]           sq_ext;
	logic [36:0]           xsum;
	logic [34:0]           qk;
	logic [34:0]           rem;
	logic [30:0]           q_fix;
	logic [INDEX_BITS-1:0] t_new;
	logic [CMP_W-1:0]      t_cmp;
	logic [15:0]           final_pos;
	logic                  last_new;

	assign stat.shape = shape_q;
	assign stat.zero  = zero_q;
	assign out_item   = out_q;

	// operand select for the shared multiplier
	always_comb begin
		unique case (cmd.op)
			lpwg_pkg::OP_SQ: begin
				mul_a = 32'(t_q);
				mul_b = 32'(t_q);
			end
			lpwg_pkg::OP_XLO: begin
				mul_a = sq_ext[31:0];
				mul_b = rate_q;
			end
			lpwg_pkg::OP_XHI: begin
				mul_a = {28'd0, sq_ext[35:32]};
				mul_b = rate_q;
			end
			lpwg_pkg::OP_TMUL: begin
				mul_a = term_q;
				mul_b = {1'b0, u_q};
			end
			lpwg_pkg::OP_TDIV: begin
				mul_a = {1'b0, p31_q};
				mul_b = lpwg_pkg::recip_q31(cmd.k);
			end
			lpwg_pkg::OP_SQR: begin
				mul_a = sum_q;
				mul_b = sum_q;
			end
			lpwg_pkg::OP_AMP: begin
				mul_a = {16'd0, amp_q};
				mul_b = sum_q;
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	assign prod     = 64'(mul_a) * 64'(mul_b);
	assign prod_rnd = prod + lpwg_pkg::Q31_HALF;
	assign sq_ext   = 64'(sq_q);
	assign xsum     = {5'd0, p_q[63:32]} + {1'b0, prod[35:0]};

	// reciprocal estimate is low by at most one
	assign qk    = 35'(qe_q) * 35'(cmd.k);
	assign rem   = 35'(p31_q) - qk;
	assign q_fix = qe_q + 31'(rem >= 35'(cmd.k));

	// index and end-of-record decision at tick time
	assign t_new     = restart ? '0 : idx_q;
	assign t_cmp     = CMP_W'(t_new);
	assign final_pos = (shape_q == lpwg_pkg::SHAPE_GAUSS) ? reclen_q :
	                   (reclen_q == 16'd0) ? 16'd0 : reclen_q - 16'd1;
	assign last_new  = t_cmp >= CMP_W'(final_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q  <= lpwg_pkg::RST_PULSE_SHAPE;
			amp_q    <= lpwg_pkg::RST_AMPLITUDE;
			rate_q   <= lpwg_pkg::RST_GAUSS_RATE;
			width_q  <= lpwg_pkg::RST_PULSE_WIDTH;
			reclen_q <= lpwg_pkg::RST_RECORD_LENGTH;
			idx_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					lpwg_pkg::CFG_PULSE_SHAPE:   shape_q  <= cfg_wdata[0];
					lpwg_pkg::CFG_AMPLITUDE:     amp_q    <= cfg_wdata[15:0];
					lpwg_pkg::CFG_GAUSS_RATE:    rate_q   <= cfg_wdata[31:0];
					lpwg_pkg::CFG_PULSE_WIDTH:   width_q  <= cfg_wdata[15:0];
					lpwg_pkg::CFG_RECORD_LENGTH: reclen_q <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			if (cmd.op == lpwg_pkg::OP_LOAD)
				idx_q <= last_new ? '0 : t_new + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			lpwg_pkg::OP_LOAD: begin
				t_q    <= t_new;
				last_q <= last_new;
			end
			lpwg_pkg::OP_SQ:  sq_q <= prod[SQ_W-1:0];
			lpwg_pkg::OP_XLO: p_q  <= prod;
			lpwg_pkg::OP_XHI: begin
				// x = t*t*rate >= 16 gives a zero sample
				zero_q <= ((rate_q != 32'd0) && (|sq_ext[63:36])) || (|xsum[36:4]);
				u_q    <= {xsum[3:0], p_q[31:5]};
				term_q <= lpwg_pkg::Q31_ONE;
				sum_q  <= lpwg_pkg::Q31_ONE;
			end
			lpwg_pkg::OP_TMUL: p31_q <= prod[61:31];
			lpwg_pkg::OP_TDIV: qe_q  <= prod[61:31];
			lpwg_pkg::OP_TFIX: begin
				term_q <= 32'(q_fix);
				sum_q  <= cmd.k[0] ? sum_q - 32'(q_fix) : sum_q + 32'(q_fix);
			end
			lpwg_pkg::OP_SQR:  sum_q <= prod_rnd[62:31];
			lpwg_pkg::OP_AMP:  res_q <= prod_rnd[46:31];
			lpwg_pkg::OP_ZERO: res_q <= 16'd0;
			lpwg_pkg::OP_RECT:
				res_q <= (CMP_W'(t_q) < CMP_W'(width_q)) ? amp_q : 16'd0;
			lpwg_pkg::OP_EMIT: begin
				out_q.sample       <= res_q & SAMPLE_MASK;
				out_q.sample_index <= 16'(t_q);
				out_q.last         <= last_q;
			end
			default: ;
		endcase
	end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Testbench for lidar_pulse_waveform_generator: streams ticks under random gaps and
// stalls, predicts each pulse sample in order and compares every field of the result.
// Depends on lpwg_pkg and lpwg_stream_if.
module tb;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 60;
	localparam int MAX_PRINT      = 40;
	localparam int RANDOM_TICKS   = 780;

	typedef struct {
		lpwg_pkg::in_item_t item;
		int                 gap;
	} tick_req_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [lpwg_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [lpwg_pkg::CFG_DATA_W-1:0] cfg_wdata;

	lpwg_stream_if #(.payload_t(lpwg_pkg::in_item_t))  tick_ch ();
	lpwg_stream_if #(.payload_t(lpwg_pkg::out_item_t)) result_ch ();

	lidar_pulse_waveform_generator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.tick     (tick_ch),
		.result   (result_ch)
	);

	// register copies and the running record position
	logic        shape_m;
	logic [15:0] amp_m;
	logic [31:0] rate_m;
	logic [15:0] width_m;
	logic [15:0] len_m;
	logic [15:0] pos_m;

	tick_req_t           tick_queue[$];
	lpwg_pkg::out_item_t sample_due[$];

	int   errors       = 0;
	int   max_idle     = 0;
	int   gap_count    = 0;
	int   stall_left   = 0;
	int   quiet_cycles = 0;
	logic tick_fire    = 1'b0;
	logic result_fire  = 1'b0;

	always #2 clk = ~clk;

	task automatic report(input string what, input longint got, input longint want);
		if (errors < MAX_PRINT)
			$display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
		errors++;
	endtask

	// amplitude * exp(-t*t*rate): Q31 series on x/16, then squared four times
	function automatic logic [15:0] gauss_level(input logic [15:0] t);
		logic [63:0] sq, u, term, sum, e;
		sq = 64'(t) * 64'(t);
		if (rate_m != 32'd0 && sq > ((64'd1 << 36) - 64'd1) / 64'(rate_m))
			return 16'd0;
		u = (sq * 64'(rate_m)) >> 5;
		term = 64'd1 << 31;
		sum = term;
		for (int k = 1; k <= lpwg_pkg::TAYLOR_TERMS; k++) begin
			term = ((term * u) >> 31) / 64'(k);
			if (k % 2 == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		e = sum;
		repeat (lpwg_pkg::SQUARINGS) e = (e * e + (64'd1 << 30)) >> 31;
		return 16'((64'(amp_m) * e + (64'd1 << 30)) >> 31);
	endfunction

	task automatic advance_record(input lpwg_pkg::in_item_t it);
		logic [15:0]         t;
		logic [15:0]         end_pos;
		lpwg_pkg::out_item_t o;
		if (it.restart)
			pos_m = 16'd0;
		t = pos_m;
		if (shape_m == lpwg_pkg::SHAPE_GAUSS) begin
			end_pos = len_m;
			o.sample = gauss_level(t);
		end else begin
			end_pos = (len_m == 16'd0) ? 16'd0 : len_m - 16'd1;
			o.sample = (t < width_m) ? amp_m : 16'd0;
		end
		o.sample_index = t;
		o.last = (t >= end_pos);
		pos_m = o.last ? 16'd0 : t + 16'd1;
		sample_due = {sample_due, o};
	endtask

	task automatic set_reg(input logic [lpwg_pkg::CFG_IDX_W-1:0] idx,
	                       input logic [lpwg_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			lpwg_pkg::CFG_PULSE_SHAPE:   shape_m = val[0];
			lpwg_pkg::CFG_AMPLITUDE:     amp_m = val[15:0];
			lpwg_pkg::CFG_GAUSS_RATE:    rate_m = val;
			lpwg_pkg::CFG_PULSE_WIDTH:   width_m = val[15:0];
			lpwg_pkg::CFG_RECORD_LENGTH: len_m = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_tick(input logic r);
		tick_req_t q;
		q.item.restart = r;
		q.gap = $urandom_range(0, max_idle);
		tick_queue = {tick_queue, q};
	endtask

	// hold until every queued tick went out and every sample came back
	task automatic settle();
		while (tick_queue.size() != 0 || tick_ch.valid || sample_due.size() != 0)
			@(posedge clk);
	endtask

	// check results, predict on tick transfers, watch for a hang
	always @(posedge clk) begin
		lpwg_pkg::out_item_t want;
		tick_fire <= tick_ch.valid && tick_ch.ready;
		result_fire <= result_ch.valid && result_ch.ready;
		if (result_ch.valid && result_ch.ready) begin
			if (sample_due.size() == 0) begin
				report("result with no sample due, index", result_ch.data.sample_index, 0);
			end else begin
				want = sample_due.pop_front();
				if (result_ch.data.sample !== want.sample)
					report("sample", result_ch.data.sample, want.sample);
				if (result_ch.data.sample_index !== want.sample_index)
					report("sample_index", result_ch.data.sample_index, want.sample_index);
				if (result_ch.data.last !== want.last)
					report("last", result_ch.data.last, want.last);
			end
		end
		if (tick_ch.valid && tick_ch.ready)
			advance_record(tick_ch.data);
		if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL lidar_pulse_waveform_generator");
			$finish;
		end
	end

	// tick driver and result stall, both on the falling edge
	always @(negedge clk) begin
		logic               nv;
		logic               nr;
		lpwg_pkg::in_item_t nd;
		if (arst_n) begin
			nv = tick_ch.valid;
			nd = tick_ch.data;
			if (tick_fire)
				nv = 1'b0;
			if (!nv && tick_queue.size() != 0) begin
				if (gap_count < tick_queue[0].gap) begin
					gap_count++;
				end else begin
					nd = tick_queue[0].item;
					void'(tick_queue.pop_front());
					nv = 1'b1;
					gap_count = 0;
				end
			end
			tick_ch.valid <= nv;
			tick_ch.data <= nd;
			if (result_fire)
				stall_left = $urandom_range(0, max_idle);
			nr = 1'b1;
			if (stall_left > 0) begin
				stall_left--;
				nr = 1'b0;
			end
			result_ch.ready <= nr;
		end
	end

	initial begin
		int          n;
		int          rpct;
		int          sent;
		int          s;
		logic [63:0] r64;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		tick_ch.valid = 1'b0;
		tick_ch.data = '0;
		result_ch.ready = 1'b0;
		shape_m = lpwg_pkg::RST_PULSE_SHAPE;
		amp_m = lpwg_pkg::RST_AMPLITUDE;
		rate_m = lpwg_pkg::RST_GAUSS_RATE;
		width_m = lpwg_pkg::RST_PULSE_WIDTH;
		len_m = lpwg_pkg::RST_RECORD_LENGTH;
		pos_m = 16'd0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: the exponent reaches 16 exactly at t = 8
		push_tick(1'b1);
		repeat (9) push_tick(1'b0);
		settle();
		// steepest rate, short record, last sample past the cutoff
		set_reg(lpwg_pkg::CFG_GAUSS_RATE, 32'hFFFF_FFFF);
		set_reg(lpwg_pkg::CFG_RECORD_LENGTH, 32'd5);
		push_tick(1'b1);
		repeat (5) push_tick(1'b0);
		settle();
		// flat exponent, one-sample record
		set_reg(lpwg_pkg::CFG_GAUSS_RATE, 32'd0);
		set_reg(lpwg_pkg::CFG_RECORD_LENGTH, 32'd0);
		push_tick(1'b0);
		push_tick(1'b1);
		settle();
		// rectangular with zero length and zero width: every sample last
		set_reg(lpwg_pkg::CFG_PULSE_SHAPE, 32'(lpwg_pkg::SHAPE_RECT));
		set_reg(lpwg_pkg::CFG_PULSE_WIDTH, 32'd0);
		set_reg(lpwg_pkg::CFG_AMPLITUDE, 32'h1234);
		push_tick(1'b0);
		push_tick(1'b0);
		settle();
		set_reg(lpwg_pkg::CFG_PULSE_WIDTH, 32'd2);
		set_reg(lpwg_pkg::CFG_RECORD_LENGTH, 32'd4);
		push_tick(1'b1);
		repeat (4) push_tick(1'b0);
		settle();
		// shrink the record under a running index
		set_reg(lpwg_pkg::CFG_RECORD_LENGTH, 32'hFFFF);
		set_reg(lpwg_pkg::CFG_PULSE_WIDTH, 32'hFFFF);
		repeat (6) push_tick(1'b0);
		settle();
		set_reg(lpwg_pkg::CFG_RECORD_LENGTH, 32'd3);
		repeat (2) push_tick(1'b0);
		settle();

		// random phases, each with fresh settings
		sent = 0;
		while (sent < RANDOM_TICKS) begin
			set_reg(lpwg_pkg::CFG_PULSE_SHAPE, $urandom_range(0, 1));
			case ($urandom_range(0, 3))
				0:       set_reg(lpwg_pkg::CFG_AMPLITUDE, 32'd0);
				1:       set_reg(lpwg_pkg::CFG_AMPLITUDE, 32'hFFFF);
				default: set_reg(lpwg_pkg::CFG_AMPLITUDE, $urandom_range(0, 65535));
			endcase
			case ($urandom_range(0, 9))
				0:       set_reg(lpwg_pkg::CFG_RECORD_LENGTH, 32'd0);
				1:       set_reg(lpwg_pkg::CFG_RECORD_LENGTH, 32'hFFFF);
				2:       set_reg(lpwg_pkg::CFG_RECORD_LENGTH, $urandom_range(0, 65535));
				default: set_reg(lpwg_pkg::CFG_RECORD_LENGTH, $urandom_range(1, 40));
			endcase
			case ($urandom_range(0, 7))
				0:       set_reg(lpwg_pkg::CFG_PULSE_WIDTH, 32'd0);
				1:       set_reg(lpwg_pkg::CFG_PULSE_WIDTH, 32'hFFFF);
				default: set_reg(lpwg_pkg::CFG_PULSE_WIDTH,
				                 $urandom_range(0, int'(len_m) + 2));
			endcase
			case ($urandom_range(0, 7))
				0:       set_reg(lpwg_pkg::CFG_GAUSS_RATE, 32'd0);
				1:       set_reg(lpwg_pkg::CFG_GAUSS_RATE, 32'hFFFF_FFFF);
				2:       set_reg(lpwg_pkg::CFG_GAUSS_RATE, $urandom());
				default: begin
					// put the cutoff somewhere inside the first few dozen samples
					s = $urandom_range(1, 40);
					r64 = ((64'd1 << 32) * 64'($urandom_range(1, 20))) / 64'(s * s);
					if (r64 > 64'hFFFF_FFFF)
						r64 = 64'hFFFF_FFFF;
					set_reg(lpwg_pkg::CFG_GAUSS_RATE, r64[31:0]);
				end
			endcase
			max_idle = ($urandom_range(0, 4) == 0) ? 0 : 17;
			case ($urandom_range(0, 2))
				0:       rpct = 0;
				1:       rpct = 5;
				default: rpct = 50;
			endcase
			n = $urandom_range(20, 80);
			for (int i = 0; i < n; i++) begin
				// drain halfway through so the sender sits idle with nothing due
				if (i == n / 2)
					settle();
				push_tick($urandom_range(0, 99) < rpct);
			end
			settle();
			sent += n;
		end

		// finish in gaussian mode with a shallow exponent
		max_idle = 17;
		set_reg(lpwg_pkg::CFG_PULSE_SHAPE, 32'(lpwg_pkg::SHAPE_GAUSS));
		set_reg(lpwg_pkg::CFG_GAUSS_RATE, 32'd15);
		repeat (3) push_tick(1'b0);
		settle();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sample_due.size() != 0)
			report("samples still due", sample_due.size(), 0);
		if (errors == 0)
			$display("PASS lidar_pulse_waveform_generator");
		else
			$display("FAIL lidar_pulse_waveform_generator");
		$finish;
	end

endmodule

>>> filelist.f
sv/lpwg_pkg.sv
sv/lpwg_stream_if.sv
sv/lpwg_ctrl.sv
sv/lpwg_dp.sv
sv/lidar_pulse_waveform_generator.sv
sim/tb.sv
